FILE: rtl/ehp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared constants, types and helpers of the Ethernet/IPv4/L4 header parser.
// ----------------------------------------------------------------------------
package ehp_pkg;

    // Frame size limit and derived widths
    localparam int MAX_FRAME = 16383;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int LEN_W     = 14;
    localparam int LEN_MAX   = 16383;
    localparam int OFF_W     = 8;
    localparam int WIDE_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Header sizes in bytes
    localparam int ETH_LEN = 14;
    localparam int ARP_LEN = 28;
    localparam int IP_MIN  = 20;
    localparam int TCP_MIN = 20;
    localparam int UDP_LEN = 8;

    // Byte positions of captured fields
    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_IHL      = ETH_LEN;
    localparam int POS_PROTO    = ETH_LEN + 9;
    localparam int POS_TCP_OFF  = ETH_LEN + 12;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Summary of one frame, handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [15:0]      ether_kind;
        logic [3:0]       ip_words;
        logic [7:0]       ip_proto;
        logic [3:0]       tcp_words;
        logic             oversize;
    } ehp_frame_t;

    // Partial result after the L2/L3 stage
    typedef struct packed {
        logic             has_eth;
        logic             has_arp;
        logic             has_ip;
        logic             tcp_req;
        logic             udp_req;
        logic [OFF_W-1:0] offset;
        logic [CNT_W-1:0] length;
        logic [CNT_W-1:0] rem;
        logic [3:0]       tcp_words;
        logic             oversize;
    } ehp_mid_t;

    typedef struct packed {
        logic             oversize;
        logic [LEN_W-1:0] body_len;
        logic [OFF_W-1:0] payload_offset;
        logic             has_udp;
        logic             has_tcp;
        logic             has_ip;
        logic             has_arp;
        logic             has_eth;
    } ehp_result_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        if (w > WIDE_W'(LEN_MAX))
            sat_len = LEN_W'(LEN_MAX);
        else
            sat_len = LEN_W'(w);
    endfunction

endpackage

FILE: rtl/eth_ip_l4_header_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ip_l4_header_parser_core
// Byte-stream Ethernet/ARP/IPv4/TCP/UDP header parser with one result per
// frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the summary queue is not full; a new
//   frame may start the cycle after a last. Each summary goes through the
//   queue, the L2/L3 stage and the L4 stage into the m_tvalid register.
// The two-entry summary queue only fills when m_tready is held low.
// Reset: rst_n clears the byte counter, captured fields, queue and valid bits.
module eth_ip_l4_header_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] has_eth, [1] has_arp, [2] has_ip,
                                   // [3] has_tcp, [4] has_udp,
                                   // [12:5] payload_offset,
                                   // [26:13] body_len, [27] oversize,
                                   // [31:28] zero
);

    logic                 q_full, q_not_empty, q_push, q_pop;
    ehp_pkg::ehp_frame_t  push_frame, q_head;
    ehp_pkg::ehp_result_t result;

    ehp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (q_push),
        .push_frame (push_frame)
    );

    ehp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_frame (push_frame),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .head       (q_head)
    );

    ehp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (q_not_empty),
        .head      (q_head),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = {4'b0000, result};

endmodule

FILE: rtl/ehp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehp_front
// Counts frame bytes, captures header fields and pushes a frame summary
// into the queue on the last byte.
// ----------------------------------------------------------------------------
module ehp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                push,
    output ehp_pkg::ehp_frame_t push_frame
);

    logic [ehp_pkg::CNT_W-1:0] count_reg, count_next;
    logic [15:0]               ether_kind_reg, ether_kind_next;
    logic [3:0]                ip_words_reg, ip_words_next;
    logic [7:0]                ip_proto_reg, ip_proto_next;
    logic [3:0]                tcp_words_reg, tcp_words_next;
    logic                      ovf_reg, ovf_next;

    logic                      accept;
    logic [ehp_pkg::CNT_W-1:0] tcp_pos;
    ehp_pkg::ehp_frame_t       upd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign tcp_pos  = ehp_pkg::CNT_W'(ehp_pkg::POS_TCP_OFF)
                    + ehp_pkg::CNT_W'({ip_words_reg, 2'b00});

    always_comb
    begin
        upd.byte_count = count_reg;
        upd.ether_kind = ether_kind_reg;
        upd.ip_words   = ip_words_reg;
        upd.ip_proto   = ip_proto_reg;
        upd.tcp_words  = tcp_words_reg;
        upd.oversize   = ovf_reg;
        if (count_reg < ehp_pkg::CNT_W'(ehp_pkg::MAX_FRAME))
        begin
            if (count_reg == ehp_pkg::CNT_W'(ehp_pkg::POS_ETYPE_HI))
                upd.ether_kind[15:8] = s_tdata;
            if (count_reg == ehp_pkg::CNT_W'(ehp_pkg::POS_ETYPE_LO))
                upd.ether_kind[7:0] = s_tdata;
            if (count_reg == ehp_pkg::CNT_W'(ehp_pkg::POS_IHL))
                upd.ip_words = s_tdata[3:0];
            if (count_reg == ehp_pkg::CNT_W'(ehp_pkg::POS_PROTO))
                upd.ip_proto = s_tdata;
            if (count_reg == tcp_pos)
                upd.tcp_words = s_tdata[7:4];
            upd.byte_count = count_reg + ehp_pkg::CNT_W'(1);
        end
        else
        begin
            upd.oversize = 1'b1;
        end
    end

    assign push       = accept && s_tlast;
    assign push_frame = upd;

    always_comb
    begin
        count_next      = count_reg;
        ether_kind_next = ether_kind_reg;
        ip_words_next   = ip_words_reg;
        ip_proto_next   = ip_proto_reg;
        tcp_words_next  = tcp_words_reg;
        ovf_next        = ovf_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                // start the next frame from scratch
                count_next      = '0;
                ether_kind_next = '0;
                ip_words_next   = '0;
                ip_proto_next   = '0;
                tcp_words_next  = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                count_next      = upd.byte_count;
                ether_kind_next = upd.ether_kind;
                ip_words_next   = upd.ip_words;
                ip_proto_next   = upd.ip_proto;
                tcp_words_next  = upd.tcp_words;
                ovf_next        = upd.oversize;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ether_kind_reg <= '0;
            ip_words_reg   <= '0;
            ip_proto_reg   <= '0;
            tcp_words_reg  <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ether_kind_reg <= ether_kind_next;
            ip_words_reg   <= ip_words_next;
            ip_proto_reg   <= ip_proto_next;
            tcp_words_reg  <= tcp_words_next;
            ovf_reg        <= ovf_next;
        end
    end

    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == '0) && !ovf_reg)
        else $error("byte count not cleared after last item");

endmodule

FILE: rtl/ehp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehp_queue
// Short queue of frame summaries between the front and back parts.
// ----------------------------------------------------------------------------
module ehp_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ehp_pkg::ehp_frame_t push_frame,
    output logic                full,
    output logic                not_empty,
    input  logic                pop,
    output ehp_pkg::ehp_frame_t head
);

    ehp_pkg::ehp_frame_t        entry_reg [ehp_pkg::QUEUE_DEPTH];
    logic [ehp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ehp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ehp_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push, do_pop;

    assign full      = (count_reg == ehp_pkg::QCNT_W'(ehp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == ehp_pkg::QPTR_W'(ehp_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + ehp_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == ehp_pkg::QPTR_W'(ehp_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + ehp_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + ehp_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - ehp_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("summary pushed into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ehp_pkg::QCNT_W'(ehp_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: rtl/ehp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehp_back
// Two-stage header walk: Ethernet/ARP/IPv4 first, then TCP/UDP and the
// length clamp into the output register.
// ----------------------------------------------------------------------------
module ehp_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 not_empty,
    input  ehp_pkg::ehp_frame_t  head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output ehp_pkg::ehp_result_t result
);

    logic                 s1_valid_reg, s1_valid_next;
    ehp_pkg::ehp_mid_t    s1_reg, s1_next;
    logic                 s2_valid_reg, s2_valid_next;
    ehp_pkg::ehp_result_t s2_reg, s2_next;
    logic                 adv1, adv2;

    logic [ehp_pkg::CNT_W-1:0] r1, ih, r2;
    logic [ehp_pkg::CNT_W-1:0] th;
    logic [ehp_pkg::CNT_W-1:0] len2;

    assign adv2 = !s2_valid_reg || m_tready;
    assign adv1 = !s1_valid_reg || adv2;
    assign pop  = adv1 && not_empty;

    // Stage 1: Ethernet, then ARP or IPv4
    always_comb
    begin
        r1 = head.byte_count - ehp_pkg::CNT_W'(ehp_pkg::ETH_LEN);
        ih = ehp_pkg::CNT_W'({head.ip_words, 2'b00});
        r2 = r1 - ih;

        s1_next.has_eth   = 1'b0;
        s1_next.has_arp   = 1'b0;
        s1_next.has_ip    = 1'b0;
        s1_next.tcp_req   = 1'b0;
        s1_next.udp_req   = 1'b0;
        s1_next.offset    = '0;
        s1_next.length    = '0;
        s1_next.rem       = r2;
        s1_next.tcp_words = head.tcp_words;
        s1_next.oversize  = head.oversize;

        if (head.byte_count >= ehp_pkg::CNT_W'(ehp_pkg::ETH_LEN))
        begin
            s1_next.has_eth = 1'b1;
            s1_next.offset  = ehp_pkg::OFF_W'(ehp_pkg::ETH_LEN);
            s1_next.length  = r1;
            if (head.ether_kind == ehp_pkg::ETHERTYPE_ARP)
            begin
                if (r1 >= ehp_pkg::CNT_W'(ehp_pkg::ARP_LEN))
                begin
                    s1_next.has_arp = 1'b1;
                    s1_next.offset  = ehp_pkg::OFF_W'(ehp_pkg::ETH_LEN + ehp_pkg::ARP_LEN);
                    s1_next.length  = r1 - ehp_pkg::CNT_W'(ehp_pkg::ARP_LEN);
                end
                else
                begin
                    s1_next.length = '0;
                end
            end
            else if (head.ether_kind == ehp_pkg::ETHERTYPE_IPV4)
            begin
                if (r1 >= ehp_pkg::CNT_W'(ehp_pkg::IP_MIN))
                begin
                    s1_next.has_ip = 1'b1;
                    s1_next.offset = ehp_pkg::OFF_W'(ehp_pkg::ETH_LEN)
                                   + ehp_pkg::OFF_W'({head.ip_words, 2'b00});
                    // a declared header longer than the frame leaves no payload
                    if (r1 < ih)
                    begin
                        s1_next.length = '0;
                    end
                    else
                    begin
                        s1_next.length  = r2;
                        s1_next.tcp_req = (head.ip_proto == ehp_pkg::PROTO_TCP);
                        s1_next.udp_req = (head.ip_proto == ehp_pkg::PROTO_UDP);
                    end
                end
                else
                begin
                    s1_next.length = '0;
                end
            end
        end
    end

    // Stage 2: TCP or UDP, clamp length
    always_comb
    begin
        th   = ehp_pkg::CNT_W'({s1_reg.tcp_words, 2'b00});
        len2 = s1_reg.length;

        s2_next.has_eth        = s1_reg.has_eth;
        s2_next.has_arp        = s1_reg.has_arp;
        s2_next.has_ip         = s1_reg.has_ip;
        s2_next.has_tcp        = 1'b0;
        s2_next.has_udp        = 1'b0;
        s2_next.payload_offset = s1_reg.offset;
        s2_next.oversize       = s1_reg.oversize;

        if (s1_reg.tcp_req)
        begin
            if (s1_reg.rem >= ehp_pkg::CNT_W'(ehp_pkg::TCP_MIN))
            begin
                s2_next.has_tcp        = 1'b1;
                s2_next.payload_offset = s1_reg.offset
                                       + ehp_pkg::OFF_W'({s1_reg.tcp_words, 2'b00});
                len2 = (s1_reg.rem < th) ? '0 : s1_reg.rem - th;
            end
            else
            begin
                len2 = '0;
            end
        end
        else if (s1_reg.udp_req)
        begin
            if (s1_reg.rem >= ehp_pkg::CNT_W'(ehp_pkg::UDP_LEN))
            begin
                s2_next.has_udp        = 1'b1;
                s2_next.payload_offset = s1_reg.offset + ehp_pkg::OFF_W'(ehp_pkg::UDP_LEN);
                len2 = s1_reg.rem - ehp_pkg::CNT_W'(ehp_pkg::UDP_LEN);
            end
            else
            begin
                len2 = '0;
            end
        end

        s2_next.body_len = ehp_pkg::sat_len(len2);
    end

    assign s1_valid_next = adv1 ? not_empty : s1_valid_reg;
    assign s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            s1_reg <= s1_next;
        if (adv2)
            s2_reg <= s2_next;
    end

    assign m_tvalid = s2_valid_reg;
    assign result   = s2_reg;

    a_l4_needs_ip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result.has_tcp || result.has_udp) |-> result.has_ip)
        else $error("L4 header reported without IPv4");

    a_l3_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(result.has_arp && result.has_ip)
                  && ((!result.has_arp && !result.has_ip) || result.has_eth))
        else $error("inconsistent L2/L3 header flags");

endmodule
